// File: rtl/ida_pkg.sv
package ida_pkg;

  // Default width of the integer taken in
  localparam int DEF_INPUT_BITS = 32;

  // Radix and characters of the text
  localparam int       DEC_BASE   = 10;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Shift-and-add-3 correction: a BCD digit of half the radix or more
  // gets the adjust added before it is doubled
  localparam logic [3:0] BCD_ADJ_MIN = 4'(DEC_BASE / 2);
  localparam logic [3:0] BCD_ADJ     = 4'(8 - DEC_BASE / 2);

  // Status handed from the converter to the character emitter
  typedef struct packed {
    logic done;
    logic neg;
  } ida_conv_t;

  // BCD digits needed for an unsigned magnitude of the given width
  function automatic int digits_for(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

// File: rtl/ida_dabble.sv
module ida_dabble
  import ida_pkg::*;
#(
  parameter int INPUT_BITS = DEF_INPUT_BITS,
  parameter int DIGITS     = digits_for(DEF_INPUT_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  start_neg,
  input  logic [INPUT_BITS-1:0] start_mag,
  output logic                  busy,
  output ida_conv_t             conv,
  output logic [4*DIGITS-1:0]   bcd
);

  localparam int CW = $clog2(INPUT_BITS + 1);

  logic [INPUT_BITS-1:0] mag_r, mag_nxt;
  logic [4*DIGITS-1:0]   bcd_r, bcd_nxt, adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_r, neg_nxt;

  // Correct every BCD digit ahead of the doubling shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= BCD_ADJ_MIN) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + BCD_ADJ;
      end else begin
        adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // Shift one magnitude bit per cycle into the BCD word, MSB first
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt = start_mag;
      bcd_nxt = '0;
      cnt_nxt = CW'(INPUT_BITS);
      run_nxt = 1'b1;
      neg_nxt = start_neg;
    end else if (run_r) begin
      mag_nxt = {mag_r[INPUT_BITS-2:0], 1'b0};
      bcd_nxt = {adj[4*DIGITS-2:0], mag_r[INPUT_BITS-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign busy      = run_r | done_r;
  assign conv.done = done_r;
  assign conv.neg  = neg_r;
  assign bcd       = bcd_r;

endmodule

// File: rtl/ida_emit.sv
module ida_emit
  import ida_pkg::*;
#(
  parameter int DIGITS = digits_for(DEF_INPUT_BITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ida_conv_t           conv,
  input  logic [4*DIGITS-1:0] bcd,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_character,
  output logic                out_last
);

  localparam int RW = $clog2(DIGITS + 1);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SIGN = 3'b010,
    E_DIG  = 3'b100
  } emit_state_t;

  emit_state_t         state_r, state_nxt;
  logic [4*DIGITS-1:0] bcd_r, bcd_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic                skip_r, skip_nxt;
  logic                valid_r, valid_nxt;
  logic [7:0]          char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [3:0]          top;
  logic                slot_free;

  assign top       = bcd_r[4*DIGITS-1 -: 4];
  assign slot_free = !valid_r || out_ready;

  // Walk the digits from the top, dropping leading zeros
  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    rem_nxt   = rem_r;
    skip_nxt  = skip_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !out_ready;
    unique case (state_r)
      E_IDLE: begin
        if (conv.done) begin
          bcd_nxt   = bcd;
          rem_nxt   = RW'(DIGITS);
          skip_nxt  = 1'b1;
          state_nxt = conv.neg ? E_SIGN : E_DIG;
        end
      end
      E_SIGN: begin
        if (slot_free) begin
          char_nxt  = CHAR_MINUS;
          last_nxt  = 1'b0;
          valid_nxt = 1'b1;
          state_nxt = E_DIG;
        end
      end
      E_DIG: begin
        if (skip_r && top == 4'd0 && rem_r > RW'(1)) begin
          bcd_nxt = {bcd_r[4*DIGITS-5:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else if (slot_free) begin
          char_nxt  = CHAR_ZERO + {4'd0, top};
          last_nxt  = (rem_r == RW'(1));
          valid_nxt = 1'b1;
          skip_nxt  = 1'b0;
          bcd_nxt   = {bcd_r[4*DIGITS-5:0], 4'd0};
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == RW'(1)) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until the word is taken
  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    rem_r  <= rem_nxt;
    skip_r <= skip_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign busy          = (state_r != E_IDLE);
  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

// File: rtl/int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
//
// Input channel: in_value is a two's complement integer, taken when
// in_valid and in_ready are both high. Output channel: one word per
// character, most significant first, '-' ahead of a negative number,
// no leading zeros, zero as a single '0'; out_last marks the final one.
//
// Operation: the word is taken and shifted bit by bit, MSB first, through a
// bit-serial shift-and-add-3 BCD converter, then handed over to the emitter,
// which sends the sign first for a negative number and then walks the BCD
// digits (DIGITS, 10 at 32 bits) from the top, sending each or dropping it as
// a leading zero; a stalled receiver holds the walk at each character to send.
//
// Reset clears the control state; no word is pending afterwards.
// A stalled receiver holds the current word in the output register and
// the emitter waits; a new item is taken once the last character of the
// previous one sits in the output register, even if not yet taken.
module int_to_decimal_ascii
  import ida_pkg::*;
#(
  parameter int INPUT_BITS = DEF_INPUT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [INPUT_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  localparam int DIGITS = digits_for(INPUT_BITS);

  logic                  start;
  logic                  neg;
  logic [INPUT_BITS-1:0] mag;
  logic                  conv_busy;
  logic                  emit_busy;
  ida_conv_t             conv;
  logic [4*DIGITS-1:0]   bcd;

  // Take a word only when both stages are free
  assign in_ready = !conv_busy && !emit_busy;
  assign start    = in_valid && in_ready;

  // Split sign and magnitude; the most negative value keeps its full size
  assign neg = in_value[INPUT_BITS-1];
  assign mag = neg ? (~in_value + 1'b1) : in_value;

  ida_dabble #(
    .INPUT_BITS(INPUT_BITS),
    .DIGITS    (DIGITS)
  ) u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_neg(neg),
    .start_mag(mag),
    .busy     (conv_busy),
    .conv     (conv),
    .bcd      (bcd)
  );

  ida_emit #(
    .DIGITS(DIGITS)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .conv         (conv),
    .bcd          (bcd),
    .busy         (emit_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

endmodule

// File: sim/tb_top.sv
module tb_top;
  import ida_pkg::*;

  localparam int VALUE_BITS     = DEF_INPUT_BITS;
  localparam int RANDOM_PER_RUN = 84;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Predict the decimal text of each accepted integer and check the characters
  class decimal_text_checker;
    text_char_t expected_chars[$];
    int         mismatches;
    int         values_noted;
    int         negatives_noted;
    int         chars_checked;
    int         longest_text;

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_value(logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      logic [7:0]            digit_codes[$];
      logic                  negative;
      int                    text_len;
      negative  = value[VALUE_BITS-1];
      // Take the magnitude unsigned so the most negative value does not overflow
      magnitude = negative ? (~value + 1'b1) : value;
      do begin
        digit_codes.push_front(CHAR_ZERO + 8'(magnitude % DEC_BASE));
        magnitude = magnitude / DEC_BASE;
      end while (magnitude != 0);
      if (negative) begin
        expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
        negatives_noted++;
      end
      foreach (digit_codes[i])
        expected_chars.push_back('{code: digit_codes[i], last: i == digit_codes.size() - 1});
      text_len = digit_codes.size() + (negative ? 1 : 0);
      if (text_len > longest_text)
        longest_text = text_len;
      values_noted++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        flag($sformatf("unexpected word char=%0d last=%0b", code, last));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code || last !== want.last)
        flag($sformatf("char exp %0d got %0d, last exp %0b got %0b",
                       want.code, code, want.last, last));
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_value  = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_character;
  logic                         out_last;

  decimal_text_checker text_check = new();
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int quiet_cycles  = 0;

  int_to_decimal_ascii #(.INPUT_BITS(VALUE_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check each accepted character, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      text_check.check_char(out_character, out_last);
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // End the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("** int_to_decimal_ascii: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one integer, idling at random first, and hold it until taken
  task automatic send_value(logic signed [VALUE_BITS-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    text_check.note_value(value);
  endtask

  // Drop valid and hold off until every expected character has arrived
  task automatic wait_for_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (text_check.pending() != 0) @(posedge clk);
  endtask

  function automatic longint unsigned power_of_ten(int exponent);
    longint unsigned p;
    p = 1;
    repeat (exponent) p = p * 10;
    return p;
  endfunction

  // Mix full-range words, values near powers of ten and a spread of digit counts
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    longint unsigned magnitude;
    longint unsigned low_mag;
    longint unsigned high_mag;
    int unsigned     kind;
    int unsigned     ndigits;
    logic            negative;
    kind     = $urandom_range(9);
    negative = 1'($urandom_range(1));
    if (kind < 3)
      return $urandom();
    if (kind < 5) begin
      magnitude = power_of_ten($urandom_range(9)) + $urandom_range(2) - 1;
    end else begin
      ndigits  = $urandom_range(1, 10);
      low_mag  = (ndigits == 1) ? 0 : power_of_ten(ndigits - 1);
      high_mag = power_of_ten(ndigits) - 1;
      if (high_mag > 64'd2147483648)
        high_mag = 64'd2147483648;
      magnitude = low_mag + ({$urandom(), $urandom()} % (high_mag - low_mag + 1));
    end
    if (magnitude > 64'd2147483648)
      magnitude = 64'd2147483648;
    if (!negative && magnitude > 64'd2147483647)
      magnitude = 64'd2147483647;
    return negative ? VALUE_BITS'(-magnitude) : VALUE_BITS'(magnitude);
  endfunction

  initial begin
    logic signed [VALUE_BITS-1:0] corner_values [20] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      32'sd100, -32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
      32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sd1234567890,
      -32'sd1234567890, 32'sh5555_5555, 32'shAAAA_AAAA
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Slow receiver: corners first, then random integers
    src_idle_pct  = 30;
    sink_idle_pct = 65;
    foreach (corner_values[i])
      send_value(corner_values[i]);
    repeat (RANDOM_PER_RUN) send_value(pick_value());
    wait_for_text();

    // Slow sender
    src_idle_pct  = 65;
    sink_idle_pct = 30;
    repeat (RANDOM_PER_RUN) send_value(pick_value());
    wait_for_text();

    // Back to back, no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (RANDOM_PER_RUN) send_value(pick_value());
    wait_for_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d integers (%0d negative) into %0d characters, longest text %0d",
             text_check.values_noted, text_check.negatives_noted,
             text_check.chars_checked, text_check.longest_text);
    $display("idle mixes: slow receiver, slow sender, none; mismatches %0d",
             text_check.mismatches);
    if (text_check.mismatches == 0 && text_check.pending() == 0)
      $display("** int_to_decimal_ascii: PASSED **");
    else
      $display("** int_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule
